FILE: design/button_debounce_idle_sleep_defines.svh
// assertion macros used by the top-level module's checks
`ifndef BUTTON_DEBOUNCE_IDLE_SLEEP_DEFINES_SVH
`define BUTTON_DEBOUNCE_IDLE_SLEEP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BDIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bdis_pkg.sv
`timescale 1ns / 1ps

package bdis_pkg;

    // field widths
    localparam int ID_W        = 3;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // default button count
    localparam int NUM_BUTTONS_DEF = 8;

    // register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 32'd120000;
    localparam logic              ENABLE_RESET   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TMO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_ENABLE = 2'd2;

    // request kinds
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] EV_SLEEP   = 2'd3;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [TIME_W-1:0] sleep_timeout_ms;
        logic              sleep_enable;
    } cfg_t;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   button_id;
        logic [TIME_W-1:0] now_ms;
    } item_t;

endpackage

FILE: design/button_debounce_idle_sleep.sv
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: button_id, now_ms; tuser: req_type
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: event_button; tuser: event_kind
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one item per cycle sustained while the result slot is not stalled by m_axis_tready
// each result passes the input register and then the result register around the lookup logic
// reset clears pressed flags, edge times, activity time and loads register defaults
// a stalled result holds the result slot; one more item waits in the input register
// cfg writes are accepted every cycle

module button_debounce_idle_sleep
    import bdis_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // button_id, now_ms, zero fill
    input  logic                   s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // event_button, zero fill
    output logic [KIND_W-1:0]      m_axis_tuser,   // event_kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "button_debounce_idle_sleep_defines.svh"

    cfg_t            cfg_q;
    item_t           in_item;
    item_t           item;
    logic            item_valid;
    logic            advance;
    logic [ID_W-1:0] event_button;

    // unpack the input transaction
    assign in_item.req_type  = s_axis_tuser;
    assign in_item.button_id = s_axis_tdata[ID_W-1:0];
    assign in_item.now_ms    = s_axis_tdata[ID_W+TIME_W-1:ID_W];

    bdis_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_q)
    );

    bdis_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bdis_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_q),
        .item_valid   (item_valid),
        .item         (item),
        .advance      (advance),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .event_kind   (m_axis_tuser),
        .event_button (event_button)
    );

    // pack the result transaction
    assign m_axis_tdata = {{(OUT_TDATA_W - ID_W){1'b0}}, event_button};

    // checks
    `BDIS_ASSERT_IMPLIES(a_button_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == EV_NONE || m_axis_tuser == EV_SLEEP),
        m_axis_tdata == '0, "button field set on an event without a button")
    `BDIS_ASSERT_IMPLIES(a_full_stall, clk, rst_n,
        m_axis_tvalid && !m_axis_tready && item_valid,
        !s_axis_tready, "input taken while both stages are full")
    `BDIS_ASSERT_NEXT(a_cfg_enable, clk, rst_n,
        cfg_valid && cfg_ready && cfg_index == REG_SLEEP_ENABLE,
        cfg_q.sleep_enable == $past(cfg_data[0]), "sleep enable write lost")

endmodule

FILE: design/bdis_cfg.sv
`timescale 1ns / 1ps

module bdis_cfg
    import bdis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:     cfg_next.debounce_ms      = cfg_data[DEB_W-1:0];
                REG_SLEEP_TMO:    cfg_next.sleep_timeout_ms = cfg_data[TIME_W-1:0];
                REG_SLEEP_ENABLE: cfg_next.sleep_enable     = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RESET;
            cfg_reg.sleep_timeout_ms <= TIMEOUT_RESET;
            cfg_reg.sleep_enable     <= ENABLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/bdis_in_stage.sv
`timescale 1ns / 1ps

module bdis_in_stage
    import bdis_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // room when empty or when the held item moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/bdis_core.sv
`timescale 1ns / 1ps

module bdis_core
    import bdis_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              item_valid,
    input  item_t             item,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] event_kind,
    output logic [ID_W-1:0]   event_button
);

    // only ids that fit the id field can ever reach a button
    localparam int MAX_IDS = 2 ** ID_W;
    localparam int DEPTH   = (NUM_BUTTONS < MAX_IDS) ? NUM_BUTTONS : MAX_IDS;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0]  pressed_reg;
    logic [DEPTH-1:0]  pressed_next;
    logic [TIME_W-1:0] last_edge_reg [DEPTH];
    logic [TIME_W-1:0] last_edge_next [DEPTH];
    logic [TIME_W-1:0] last_act_reg;
    logic [TIME_W-1:0] last_act_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   btn_reg;

    logic [IDX_W-1:0]  idx;
    logic              id_in_range;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] idle;
    logic              btn_ok;
    logic              sleep_ok;
    logic [KIND_W-1:0] kind_calc;
    logic [ID_W-1:0]   btn_calc;

    // move on when the result slot is free or being drained
    assign advance = item_valid && (!out_valid_reg || out_ready);

    // lookup and compare
    assign idx         = IDX_W'(item.button_id);
    assign id_in_range = ({1'b0, item.button_id} < (ID_W + 1)'(DEPTH));
    assign since       = item.now_ms - last_edge_reg[idx];
    assign idle        = item.now_ms - last_act_reg;
    assign btn_ok      = (item.req_type == REQ_EDGE) && id_in_range
                         && (since >= {{(TIME_W - DEB_W){1'b0}}, cfg.debounce_ms});
    assign sleep_ok    = (item.req_type == REQ_POLL) && cfg.sleep_enable
                         && (idle > cfg.sleep_timeout_ms);

    // result selection
    always_comb
    begin
        kind_calc = EV_NONE;
        btn_calc  = '0;
        if (btn_ok)
        begin
            kind_calc = pressed_reg[idx] ? EV_RELEASE : EV_PRESS;
            btn_calc  = item.button_id;
        end
        else if (sleep_ok)
        begin
            kind_calc = EV_SLEEP;
        end
    end

    // state update
    always_comb
    begin
        pressed_next   = pressed_reg;
        last_edge_next = last_edge_reg;
        last_act_next  = last_act_reg;
        if (advance && btn_ok)
        begin
            pressed_next[idx]   = ~pressed_reg[idx];
            last_edge_next[idx] = item.now_ms;
            last_act_next       = item.now_ms;
        end
        else if (advance && sleep_ok)
        begin
            last_act_next = item.now_ms;
        end
    end

    // result slot valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg   <= '0;
            last_act_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                last_edge_reg[i] <= '0;
            end
        end
        else
        begin
            pressed_reg   <= pressed_next;
            last_edge_reg <= last_edge_next;
            last_act_reg  <= last_act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= kind_calc;
            btn_reg  <= btn_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign event_button = btn_reg;

endmodule

FILE: bench/button_debounce_idle_sleep_tb.sv
`timescale 1ns / 1ps

module button_debounce_idle_sleep_tb;
    import bdis_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   button;
    } event_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // dut ports
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // button_id, now_ms, zero fill
    logic                   s_axis_tuser = 1'b0; // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // event_button, zero fill
    logic [KIND_W-1:0]      m_axis_tuser;        // event_kind
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    button_debounce_idle_sleep uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow copy of the debouncer and its registers
    logic [DEB_W-1:0]  cfg_deb;
    logic [TIME_W-1:0] cfg_tmo;
    logic              cfg_en;
    logic              btn_held [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0] btn_stamp [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0] idle_ref_ms;

    // stimulus and scoreboard state
    item_t       pending_items [$];
    event_t      expected_events [$];
    item_t       drv_item;
    logic [TIME_W-1:0] gen_ms = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        send_hold = 1'b0;
    int          err_cnt = 0;

    // append to the pending queue
    function automatic void enqueue(input item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // lockout debounce and idle timer, one event per transaction
    function automatic void predict_event(input item_t it);
        event_t ev;
        logic [TIME_W-1:0] gap;
        ev.kind = EV_NONE;
        ev.button = '0;
        if (it.req_type == REQ_EDGE) begin
            if (int'(it.button_id) < NUM_BUTTONS_DEF) begin
                gap = it.now_ms - btn_stamp[it.button_id];
                if (gap >= TIME_W'(cfg_deb)) begin
                    ev.kind = btn_held[it.button_id] ? EV_RELEASE : EV_PRESS;
                    ev.button = it.button_id;
                    btn_held[it.button_id] = ~btn_held[it.button_id];
                    btn_stamp[it.button_id] = it.now_ms;
                    idle_ref_ms = it.now_ms;
                end
            end
        end
        else begin
            gap = it.now_ms - idle_ref_ms;
            if (cfg_en && gap > cfg_tmo) begin
                ev.kind = EV_SLEEP;
                idle_ref_ms = it.now_ms;
            end
        end
        expected_events.insert(expected_events.size(), ev);
    endfunction

    function automatic item_t make_item(input logic kind, input int unsigned id,
                                        input logic [TIME_W-1:0] t);
        item_t it;
        it.req_type = kind;
        it.button_id = ID_W'(id);
        it.now_ms = t;
        return it;
    endfunction

    // random item: mostly time steps around the lockout and the timeout, some noise
    function automatic item_t gen_item(input logic [DEB_W-1:0] deb,
                                       input logic [TIME_W-1:0] tmo);
        item_t it;
        int unsigned r;
        logic [TIME_W-1:0] step;
        r = $urandom_range(99);
        it.button_id = ID_W'($urandom_range(NUM_BUTTONS_DEF - 1));
        if (r < 6) begin
            it.req_type = 1'($urandom_range(1));
            it.now_ms = $urandom();
            return it;
        end
        if (r < 72) begin
            it.req_type = REQ_EDGE;
            case ($urandom_range(3))
                0: step = $urandom_range(deb);
                1: step = TIME_W'(deb);
                2: step = TIME_W'(deb) + $urandom_range(deb);
                default: step = $urandom_range(3);
            endcase
        end
        else begin
            it.req_type = REQ_POLL;
            case ($urandom_range(3))
                0: step = $urandom_range(3);
                1: step = tmo + $urandom_range(2) - 1;
                2: step = $urandom_range(tmo >> 1);
                default: step = tmo + $urandom_range(tmo >> 2);
            endcase
        end
        gen_ms = gen_ms + step;
        it.now_ms = gen_ms;
        return it;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_event(drv_item);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({drv_item.now_ms, drv_item.button_id});
                    s_axis_tuser  <= drv_item.req_type;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d button %0d", $time,
                             m_axis_tuser, m_axis_tdata[ID_W-1:0]);
                    err_cnt++;
                end
                else
                begin
                    event_t ev;
                    ev = expected_events.pop_front();
                    if (m_axis_tuser !== ev.kind)
                    begin
                        $display("%0t: event_kind expected %0d actual %0d", $time,
                                 ev.kind, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata[ID_W-1:0] !== ev.button)
                    begin
                        $display("%0t: event_button expected %0d actual %0d", $time,
                                 ev.button, m_axis_tdata[ID_W-1:0]);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // config writes, called right after a rising edge with the block idle
    task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] tmo,
                              input logic en);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{REG_DEBOUNCE, REG_SLEEP_TMO, REG_SLEEP_ENABLE};
        val = '{CFG_DATA_W'(deb), tmo, CFG_DATA_W'(en)};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                REG_DEBOUNCE:     cfg_deb = val[k][DEB_W-1:0];
                REG_SLEEP_TMO:    cfg_tmo = val[k];
                REG_SLEEP_ENABLE: cfg_en  = val[k][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_events.size() != 0);
    endtask

    // one phase: drain, reprogram, then a burst of random transactions
    task automatic run_phase(input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] tmo,
                             input logic en, input int unsigned sidle,
                             input int unsigned rstall, input int n, input bit pause_mid);
        wait_drained();
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (4) @(posedge clk);
        write_regs(deb, tmo, en);
        @(negedge clk);
        for (int k = 0; k < n; k++)
        begin
            // hold the sender once until every result is back
            if (pause_mid && k == n / 2)
            begin
                do @(negedge clk); while (pending_items.size() != 0);
                send_hold = 1'b1;
                do @(negedge clk); while (s_axis_tvalid || expected_events.size() != 0);
                send_hold = 1'b0;
            end
            enqueue(gen_item(deb, tmo));
        end
    endtask

    // main sequence
    initial
    begin
        cfg_deb = DEBOUNCE_RESET;
        cfg_tmo = TIMEOUT_RESET;
        cfg_en  = ENABLE_RESET;
        idle_ref_ms = '0;
        for (int b = 0; b < NUM_BUTTONS_DEF; b++)
        begin
            btn_held[b] = 1'b0;
            btn_stamp[b] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: early edges, lockout edges, wrap of the time, poll boundaries
        enqueue(make_item(REQ_EDGE, 0, 32'd0));
        enqueue(make_item(REQ_EDGE, 0, 32'd19));
        enqueue(make_item(REQ_EDGE, 0, 32'd20));
        enqueue(make_item(REQ_EDGE, 0, 32'd39));
        enqueue(make_item(REQ_EDGE, 0, 32'd40));
        enqueue(make_item(REQ_EDGE, 7, 32'd100));
        enqueue(make_item(REQ_EDGE, 3, 32'hFFFF_FFFF));
        enqueue(make_item(REQ_POLL, 5, 32'd50));
        enqueue(make_item(REQ_POLL, 0, 32'd119999));
        enqueue(make_item(REQ_POLL, 7, 32'd120000));
        enqueue(make_item(REQ_POLL, 2, 32'd120000));
        enqueue(make_item(REQ_EDGE, 3, 32'd10));
        enqueue(make_item(REQ_EDGE, 3, 32'd18));
        enqueue(make_item(REQ_EDGE, 3, 32'd19));
        for (int b = 1; b < 7; b++)
            enqueue(make_item(REQ_EDGE, b, 32'h7FFF_FFFF));
        enqueue(make_item(REQ_POLL, 0, 32'h8001_D4C0));

        // random phases across register extremes and flow control mixes
        run_phase('0, '0, 1'b1, 0, 0, 220, 1'b0);
        run_phase(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 65, 0, 220, 1'b0);
        run_phase(DEB_W'($urandom_range(40, 1)), $urandom_range(400, 50), 1'b0,
                  0, 65, 220, 1'b0);
        run_phase(DEB_W'($urandom_range(40, 1)), $urandom_range(400, 50), 1'b1,
                  22, 22, 220, 1'b0);
        run_phase(DEB_W'($urandom_range(200)), $urandom_range(2000), 1'b1,
                  0, 0, 220, 1'b1);
        run_phase(DEBOUNCE_RESET, TIMEOUT_RESET, ENABLE_RESET, 65, 0, 220, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("button_debounce_idle_sleep_tb: done, clean");
        else
            $display("button_debounce_idle_sleep_tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("button_debounce_idle_sleep_tb: done, errors");
        $finish;
    end

endmodule
